[hdl/sfs_pkg.sv]
// Shared types, constants and CORDIC angle table for the swim stroke foot setpoint block.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_W = $clog2(MAX_POINTS);

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_PER_STAGE = 4;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam int ROT_W = 34;

  localparam int SQRT_BITS = 16;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_PER_STAGE = SQRT_BITS / SQRT_STAGES;

  localparam int DIV_PER_STAGE = 8;
  localparam int DIV_BITS = PT_W + 32;
  localparam int DIV_STAGES = (DIV_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int DIV_NUM_W = DIV_STAGES * DIV_PER_STAGE - 32;

  // Cycle counts of the speed and rotation units, from the input sample to the registered output, and in total
  localparam int SPEED_XY_LAT = 5 + SQRT_STAGES;
  localparam int ROT_LAT = 1 + CORDIC_STAGES;
  localparam int LATENCY = SPEED_XY_LAT + ROT_LAT + 1 + ROT_LAT + 1;

  localparam logic [31:0] UNIT_Q30 = 32'd652032874;
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131497;

  localparam logic [31:0] ARC_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_FWD_VEL,
    CFG_VERT_VEL,
    CFG_PITCH_RATE,
    CFG_HIP_RADIUS,
    CFG_INV_GAIN,
    CFG_LEG_LENGTH,
    CFG_VERT_AMP,
    CFG_POINTS
  } sfs_cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] forward_velocity;
    logic signed [15:0] vertical_velocity;
    logic signed [15:0] pitch_rate;
    logic [15:0]        hip_radius;
    logic [15:0]        inverse_amplitude_gain;
    logic [14:0]        leg_length;
    logic [14:0]        vertical_amplitude;
    logic [11:0]        points_per_stroke;
  } sfs_cfg_t;

  typedef struct packed {
    logic [1:0]      leg_number;
    logic [PT_W-1:0] point_index;
  } sfs_in_t;

  typedef struct packed {
    logic signed [15:0] foot_x;
    logic signed [15:0] foot_z;
  } sfs_out_t;

endpackage

`default_nettype wire

[hdl/sfs_speed.sv]
// Leg velocity, speed square root, stroke amplitude and tilt vector components.
`timescale 1ns / 1ps
`default_nettype none

module sfs_speed (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire sfs_pkg::sfs_cfg_t cfg,
  input  wire logic [1:0]        leg,
  output logic signed [15:0]     vx_o,
  output logic signed [17:0]     vy_o,
  output logic [19:0]            amp_o
);

  localparam int NS = sfs_pkg::SQRT_STAGES;
  localparam int NP = sfs_pkg::SQRT_PER_STAGE;

  logic signed [32:0] prod_r;
  logic [1:0]         leg_r;
  logic signed [15:0] vz2_r;
  logic signed [15:0] vz3_r;
  logic [30:0]        sqx_r;
  logic [30:0]        sqz_r;

  logic [31:0]        rad_r  [NS+1];
  logic [17:0]        rem_r  [NS+1];
  logic [15:0]        root_r [NS+1];
  logic signed [15:0] vzq_r  [NS+1];
  logic [31:0]        rad_nxt  [NS];
  logic [17:0]        rem_nxt  [NS];
  logic [15:0]        root_nxt [NS];

  logic signed [17:0] vy_r;
  logic [15:0]        v9_r;
  logic [31:0]        ap_r;
  logic [19:0]        amp_r;

  logic signed [17:0] term_w;
  logic signed [17:0] vzc_w;
  logic signed [17:0] vz_sum;
  logic signed [15:0] vz2_nxt;
  logic signed [31:0] sqx_w;
  logic signed [31:0] sqz_w;
  logic [32:0]        amp_sum;

  always_comb begin
    term_w = 18'(($signed(prod_r) + 33'sd32768) >>> 16);
    vzc_w = 18'($signed(cfg.vertical_velocity));
    if (leg_r == 2'd0 || leg_r == 2'd3) begin
      vz_sum = vzc_w + term_w;
    end else begin
      vz_sum = vzc_w - term_w;
    end
    if (vz_sum > 18'sd32767) begin
      vz2_nxt = 16'sh7FFF;
    end else if (vz_sum < -18'sd32768) begin
      vz2_nxt = 16'sh8000;
    end else begin
      vz2_nxt = vz_sum[15:0];
    end
    sqx_w = $signed(cfg.forward_velocity) * $signed(cfg.forward_velocity);
    sqz_w = vz2_r * vz2_r;
  end

  // Square root, two radicand bits per step
  always_comb begin
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
    logic [19:0] cur;
    logic [19:0] trial;
    for (int s = 0; s < NS; s++) begin
      rad = rad_r[s];
      rem = rem_r[s];
      root = root_r[s];
      for (int j = 0; j < NP; j++) begin
        cur = {rem, rad[31:30]};
        trial = {2'b00, root, 2'b01};
        if (cur >= trial) begin
          rem = 18'(cur - trial);
          root = {root[14:0], 1'b1};
        end else begin
          rem = cur[17:0];
          root = {root[14:0], 1'b0};
        end
        rad = {rad[29:0], 2'b00};
      end
      rad_nxt[s] = rad;
      rem_nxt[s] = rem;
      root_nxt[s] = root;
    end
  end

  assign amp_sum = {1'b0, ap_r} + 33'd4096;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= $signed(cfg.pitch_rate) * $signed({1'b0, cfg.hip_radius});
      leg_r <= leg;
      vz2_r <= vz2_nxt;
      sqx_r <= sqx_w[30:0];
      sqz_r <= sqz_w[30:0];
      vz3_r <= vz2_r;
      rad_r[0] <= {1'b0, sqx_r} + {1'b0, sqz_r};
      rem_r[0] <= '0;
      root_r[0] <= '0;
      vzq_r[0] <= vz3_r;
      for (int s = 0; s < NS; s++) begin
        rad_r[s+1] <= rad_nxt[s];
        rem_r[s+1] <= rem_nxt[s];
        root_r[s+1] <= root_nxt[s];
        vzq_r[s+1] <= vzq_r[s];
      end
      vy_r <= 18'(vzq_r[NS]) - $signed({2'b00, root_r[NS]});
      v9_r <= root_r[NS];
      ap_r <= v9_r * cfg.inverse_amplitude_gain;
      amp_r <= amp_sum[32:13];
    end
  end

  assign vx_o = cfg.forward_velocity;
  assign vy_o = vy_r;
  assign amp_o = amp_r;

endmodule

`default_nettype wire

[hdl/sfs_phase.sv]
// Stroke phase: point index times one turn divided by the stroke length, long division.
`timescale 1ns / 1ps
`default_nettype none

module sfs_phase (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [sfs_pkg::PT_W-1:0] idx,
  input  wire logic [11:0]              points,
  output logic [31:0]                   phase_o
);

  localparam int NS = sfs_pkg::DIV_STAGES;
  localparam int NP = sfs_pkg::DIV_PER_STAGE;
  localparam int NW = sfs_pkg::DIV_NUM_W;

  logic [NW-1:0] num_r [NS];
  logic [11:0]   rem_r [NS];
  logic [31:0]   quo_r [NS];
  logic [NW-1:0] num_nxt [NS];
  logic [11:0]   rem_nxt [NS];
  logic [31:0]   quo_nxt [NS];
  logic [11:0]   den;

  // Zero length acts as one
  always_comb begin
    if (points == 12'd0) begin
      den = 12'd1;
    end else if (13'(points) > 13'(sfs_pkg::MAX_POINTS)) begin
      den = 12'(sfs_pkg::MAX_POINTS);
    end else begin
      den = points;
    end
  end

  always_comb begin
    logic [NW-1:0] num;
    logic [11:0]   rem;
    logic [31:0]   quo;
    logic [12:0]   t;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        num = NW'(idx);
        rem = '0;
        quo = '0;
      end else begin
        num = num_r[s-1];
        rem = rem_r[s-1];
        quo = quo_r[s-1];
      end
      for (int j = 0; j < NP; j++) begin
        t = {rem, num[NW-1]};
        if (t >= {1'b0, den}) begin
          rem = 12'(t - {1'b0, den});
          quo = {quo[30:0], 1'b1};
        end else begin
          rem = t[11:0];
          quo = {quo[30:0], 1'b0};
        end
        num = {num[NW-2:0], 1'b0};
      end
      num_nxt[s] = num;
      rem_nxt[s] = rem;
      quo_nxt[s] = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        num_r[s] <= num_nxt[s];
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign phase_o = quo_r[NS-1];

endmodule

`default_nettype wire

[hdl/sfs_vector.sv]
// CORDIC vectoring: doubled angle of (x, y) in turns, zero for the zero vector.
`timescale 1ns / 1ps
`default_nettype none

module sfs_vector (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [17:0] y_i,
  output logic [31:0]      tilt_o
);

  localparam int W = sfs_pkg::ROT_W;
  localparam int NS = sfs_pkg::CORDIC_STAGES;
  localparam int NP = sfs_pkg::CORDIC_PER_STAGE;

  logic signed [W-1:0] x_r [NS+1];
  logic signed [W-1:0] y_r [NS+1];
  logic signed [W-1:0] z_r [NS+1];
  logic                zero_r [NS+1];
  logic signed [W-1:0] x_nxt [NS];
  logic signed [W-1:0] y_nxt [NS];
  logic signed [W-1:0] z_nxt [NS];
  logic signed [W-1:0] x0_nxt;
  logic signed [W-1:0] y0_nxt;

  // Fold the left half plane onto the right; the half turn drops out when doubled
  always_comb begin
    if (x_i < 16'sd0) begin
      x0_nxt = -(W'(x_i) <<< 14);
      y0_nxt = -(W'(y_i) <<< 14);
    end else begin
      x0_nxt = W'(x_i) <<< 14;
      y0_nxt = W'(y_i) <<< 14;
    end
  end

  always_comb begin
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    int k;
    for (int s = 0; s < NS; s++) begin
      x = x_r[s];
      y = y_r[s];
      z = z_r[s];
      for (int j = 0; j < NP; j++) begin
        k = s * NP + j;
        dx = y >>> k;
        dy = x >>> k;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + $signed(W'(sfs_pkg::ARC_TAB[k]));
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - $signed(W'(sfs_pkg::ARC_TAB[k]));
        end
      end
      x_nxt[s] = x;
      y_nxt[s] = y;
      z_nxt[s] = z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= '0;
      zero_r[0] <= (x_i == 16'sd0) && (y_i == 18'sd0);
      for (int s = 0; s < NS; s++) begin
        x_r[s+1] <= x_nxt[s];
        y_r[s+1] <= y_nxt[s];
        z_r[s+1] <= z_nxt[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  assign tilt_o = zero_r[NS] ? 32'd0 : {z_r[NS][30:0], 1'b0};

endmodule

`default_nettype wire

[hdl/sfs_rotate.sv]
// CORDIC rotation of (x, y) counterclockwise by an angle in turns, gain kept.
`timescale 1ns / 1ps
`default_nettype none

module sfs_rotate (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [sfs_pkg::ROT_W-1:0]  x_i,
  input  wire logic signed [sfs_pkg::ROT_W-1:0]  y_i,
  input  wire logic [31:0]                       ang_i,
  output logic signed [sfs_pkg::ROT_W-1:0]       x_o,
  output logic signed [sfs_pkg::ROT_W-1:0]       y_o
);

  localparam int W = sfs_pkg::ROT_W;
  localparam int NS = sfs_pkg::CORDIC_STAGES;
  localparam int NP = sfs_pkg::CORDIC_PER_STAGE;

  logic signed [W-1:0] x_r [NS+1];
  logic signed [W-1:0] y_r [NS+1];
  logic signed [W-1:0] z_r [NS+1];
  logic signed [W-1:0] x_nxt [NS];
  logic signed [W-1:0] y_nxt [NS];
  logic signed [W-1:0] z_nxt [NS];
  logic signed [W-1:0] x0_nxt;
  logic signed [W-1:0] y0_nxt;
  logic [31:0]         a0;

  // Second and third quadrants: negate and turn by half a turn
  always_comb begin
    if (ang_i[31:30] == 2'd1 || ang_i[31:30] == 2'd2) begin
      x0_nxt = -x_i;
      y0_nxt = -y_i;
      a0 = ang_i + 32'h80000000;
    end else begin
      x0_nxt = x_i;
      y0_nxt = y_i;
      a0 = ang_i;
    end
  end

  always_comb begin
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    int k;
    for (int s = 0; s < NS; s++) begin
      x = x_r[s];
      y = y_r[s];
      z = z_r[s];
      for (int j = 0; j < NP; j++) begin
        k = s * NP + j;
        dx = y >>> k;
        dy = x >>> k;
        if (!z[W-1]) begin
          x = x - dx;
          y = y + dy;
          z = z - $signed(W'(sfs_pkg::ARC_TAB[k]));
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + $signed(W'(sfs_pkg::ARC_TAB[k]));
        end
      end
      x_nxt[s] = x;
      y_nxt[s] = y;
      z_nxt[s] = z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= W'($signed(a0));
      for (int s = 0; s < NS; s++) begin
        x_r[s+1] <= x_nxt[s];
        y_r[s+1] <= y_nxt[s];
        z_r[s+1] <= z_nxt[s];
      end
    end
  end

  assign x_o = x_r[NS];
  assign y_o = y_r[NS];

endmodule

`default_nettype wire

[hdl/sfs_scale.sv]
// Ellipse point from amplitude and phase vector, prescaled by the CORDIC gain reciprocal.
`timescale 1ns / 1ps
`default_nettype none

module sfs_scale (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire sfs_pkg::sfs_cfg_t                cfg,
  input  wire logic [19:0]                      amp,
  input  wire logic signed [sfs_pkg::ROT_W-1:0] c_i,
  input  wire logic signed [sfs_pkg::ROT_W-1:0] s_i,
  output logic signed [sfs_pkg::ROT_W-1:0]      xp_o,
  output logic signed [sfs_pkg::ROT_W-1:0]      zp_o
);

  localparam int W = sfs_pkg::ROT_W;

  logic signed [52:0]  pa_r;
  logic signed [47:0]  ps_r;
  logic signed [31:0]  xp1_r;
  logic signed [31:0]  zp1_r;
  logic signed [64:0]  mx_r;
  logic signed [64:0]  mz_r;
  logic signed [W-1:0] xp_r;
  logic signed [W-1:0] zp_r;
  logic signed [31:0]  zs_w;
  logic signed [31:0]  leg_w;
  logic signed [32:0]  inv_w;

  assign zs_w = 32'((ps_r + 48'sd1048576) >>> 21);
  assign leg_w = $signed({8'd0, cfg.leg_length, 9'd0});
  assign inv_w = $signed({1'b0, sfs_pkg::INV_GAIN_Q32});

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= $signed({1'b0, amp}) * $signed(c_i[31:0]);
      ps_r <= $signed({1'b0, cfg.vertical_amplitude}) * $signed(s_i[31:0]);
      xp1_r <= 32'((pa_r + 53'sd1048576) >>> 21);
      zp1_r <= zs_w - leg_w;
      mx_r <= xp1_r * inv_w;
      mz_r <= zp1_r * inv_w;
      xp_r <= W'((mx_r + 65'sd2147483648) >>> 32);
      zp_r <= W'((mz_r + 65'sd2147483648) >>> 32);
    end
  end

  assign xp_o = xp_r;
  assign zp_o = zp_r;

endmodule

`default_nettype wire

[hdl/swim_stroke_foot_setpoint.sv]
// Swim stroke foot setpoint generator: top level with register file and output stage.
//
// Input channel in_valid/in_ready/in_data carries a leg number and a point index;
// result channel out_valid/out_ready/out_data returns the saturated Q0.15 foot
// position (x, z) for that point. One result per item, in order.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index at the clock
// edge; change registers only while no item is in flight.
// Pipeline: 21 register stages from the accepting edge to out_valid
// (speed square root 9 stages, tilt vectoring 5, one alignment register, final
// rotation 5, output register 1; the phase divider and phase rotation run alongside
// the speed path).
// Throughput: one item per cycle unless held; every stage is a register with a valid bit.
// When the receiver holds out_ready low with a result waiting, the whole pipeline
// holds and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
// defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module swim_stroke_foot_setpoint (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sfs_pkg::sfs_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sfs_pkg::sfs_out_t      out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wr_data
);

  localparam int W = sfs_pkg::ROT_W;
  localparam int L = sfs_pkg::LATENCY;

  sfs_pkg::sfs_cfg_t  cfg_r;
  sfs_pkg::sfs_out_t  out_r;
  logic [L-1:0]       valid_r;
  logic               en;

  logic signed [15:0] vx;
  logic signed [17:0] vy;
  logic [19:0]        amp;
  logic [31:0]        phase;
  logic [31:0]        tilt;
  logic [31:0]        tilt_r;
  logic signed [W-1:0] c_w;
  logic signed [W-1:0] s_w;
  logic signed [W-1:0] xp_w;
  logic signed [W-1:0] zp_w;
  logic signed [W-1:0] xf_w;
  logic signed [W-1:0] zf_w;
  logic signed [W-10:0] xr_w;
  logic signed [W-10:0] zr_w;
  sfs_pkg::sfs_out_t  out_nxt;

  // Advance everything unless a finished result is waiting with out_ready low
  assign en = !valid_r[L-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.forward_velocity <= '0;
      cfg_r.vertical_velocity <= '0;
      cfg_r.pitch_rate <= '0;
      cfg_r.hip_radius <= 16'd17695;
      cfg_r.inverse_amplitude_gain <= 16'd13107;
      cfg_r.leg_length <= 15'd5898;
      cfg_r.vertical_amplitude <= 15'd164;
      cfg_r.points_per_stroke <= 12'd71;
      valid_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (sfs_pkg::sfs_cfg_idx_t'(cfg_index))
          sfs_pkg::CFG_FWD_VEL:    cfg_r.forward_velocity <= cfg_wr_data;
          sfs_pkg::CFG_VERT_VEL:   cfg_r.vertical_velocity <= cfg_wr_data;
          sfs_pkg::CFG_PITCH_RATE: cfg_r.pitch_rate <= cfg_wr_data;
          sfs_pkg::CFG_HIP_RADIUS: cfg_r.hip_radius <= cfg_wr_data;
          sfs_pkg::CFG_INV_GAIN:   cfg_r.inverse_amplitude_gain <= cfg_wr_data;
          sfs_pkg::CFG_LEG_LENGTH: cfg_r.leg_length <= cfg_wr_data[14:0];
          sfs_pkg::CFG_VERT_AMP:   cfg_r.vertical_amplitude <= cfg_wr_data[14:0];
          sfs_pkg::CFG_POINTS:     cfg_r.points_per_stroke <= cfg_wr_data[11:0];
        endcase
      end
      if (en) begin
        valid_r <= {valid_r[L-2:0], in_valid};
      end
    end
  end

  sfs_speed u_speed (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg_r),
    .leg   (in_data.leg_number),
    .vx_o  (vx),
    .vy_o  (vy),
    .amp_o (amp)
  );

  sfs_phase u_phase (
    .clk     (clk),
    .en      (en),
    .idx     (in_data.point_index),
    .points  (cfg_r.points_per_stroke),
    .phase_o (phase)
  );

  sfs_rotate u_rot_phase (
    .clk   (clk),
    .en    (en),
    .x_i   (W'(sfs_pkg::UNIT_Q30)),
    .y_i   ('0),
    .ang_i (phase),
    .x_o   (c_w),
    .y_o   (s_w)
  );

  sfs_vector u_vector (
    .clk    (clk),
    .en     (en),
    .x_i    (vx),
    .y_i    (vy),
    .tilt_o (tilt)
  );

  sfs_scale u_scale (
    .clk  (clk),
    .en   (en),
    .cfg  (cfg_r),
    .amp  (amp),
    .c_i  (c_w),
    .s_i  (s_w),
    .xp_o (xp_w),
    .zp_o (zp_w)
  );

  // Align the tilt with the scaled ellipse point
  always_ff @(posedge clk) begin
    if (en) begin
      tilt_r <= tilt;
    end
  end

  sfs_rotate u_rot_tilt (
    .clk   (clk),
    .en    (en),
    .x_i   (xp_w),
    .y_i   (zp_w),
    .ang_i (tilt_r),
    .x_o   (xf_w),
    .y_o   (zf_w)
  );

  always_comb begin
    xr_w = (W-9)'((xf_w + W'(256)) >>> 9);
    zr_w = (W-9)'((zf_w + W'(256)) >>> 9);
    if (xr_w > (W-9)'(32767)) begin
      out_nxt.foot_x = 16'sh7FFF;
    end else if (xr_w < -(W-9)'(32768)) begin
      out_nxt.foot_x = 16'sh8000;
    end else begin
      out_nxt.foot_x = xr_w[15:0];
    end
    if (zr_w > (W-9)'(32767)) begin
      out_nxt.foot_z = 16'sh7FFF;
    end else if (zr_w < -(W-9)'(32768)) begin
      out_nxt.foot_z = 16'sh8000;
    end else begin
      out_nxt.foot_z = zr_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r[L-1];
  assign out_data = out_r;

endmodule

`default_nettype wire

[hdl/sfs_check.sv]
// Port checker for the foot setpoint block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sfs_check (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire sfs_pkg::sfs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while the pipeline is held");

  a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with no result waiting");

endmodule

bind swim_stroke_foot_setpoint sfs_check u_sfs_check (.*);

`default_nettype wire

[tb/sv/sfs_checker.sv]
// Result checker for the swim stroke foot setpoint block: predicts each setpoint and compares.
`timescale 1ns / 1ps
`default_nettype none

module sfs_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire sfs_pkg::sfs_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire sfs_pkg::sfs_out_t out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wr_data,
  output int                     fail_count,
  output int                     pending_count,
  output int                     result_count
);
  import sfs_pkg::*;

  sfs_cfg_t regs;
  sfs_out_t setpoint_q[$];

  function automatic longint asr64(longint v, int n);
    return v >>> n;
  endfunction

  // Rotate counterclockwise by ang turns, CORDIC gain kept.
  function automatic void turn_vec(inout longint x, inout longint y, input logic [31:0] ang);
    longint z, dx, dy;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      ang = ang + 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = asr64(y, k);
      dy = asr64(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC_TAB[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC_TAB[k]);
      end
    end
  endfunction

  function automatic logic [31:0] heading(longint x, longint y);
    logic [31:0] base;
    longint z, dx, dy;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 32'h80000000;
    end
    x *= 16384;
    y *= 16384;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = asr64(y, k);
      dy = asr64(x, k);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ARC_TAB[k]);
      end else begin
        x -= dx; y += dy; z -= longint'(ARC_TAB[k]);
      end
    end
    return base + z[31:0];
  endfunction

  function automatic longint sqrt_floor(longint s);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic sfs_out_t foot_setpoint(sfs_in_t item);
    longint vx, vzc, wy, term, vz, v, amp, c, s, xp, zp, n, idx;
    logic [31:0] tilt, phase;
    logic [63:0] num;
    sfs_out_t r;
    vx = regs.forward_velocity;
    vzc = regs.vertical_velocity;
    wy = regs.pitch_rate;
    term = asr64(wy * longint'(regs.hip_radius) + 32768, 16);
    vz = clip16((item.leg_number == 0 || item.leg_number == 3) ? vzc + term : vzc - term);
    v = sqrt_floor(vx * vx + vz * vz);
    amp = asr64(v * longint'(regs.inverse_amplitude_gain) + 4096, 13);
    tilt = heading(vx, vz - v) << 1;
    n = regs.points_per_stroke;
    if (n == 0) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    idx = item.point_index;
    num = 64'(idx) << 32;
    phase = 32'(num / 64'(n));
    c = UNIT_Q30;
    s = 0;
    turn_vec(c, s, phase);
    xp = asr64(amp * c + (64'sd1 <<< 20), 21);
    zp = asr64(longint'(regs.vertical_amplitude) * s + (64'sd1 <<< 20), 21)
         - longint'(regs.leg_length) * 512;
    xp = asr64(xp * longint'(INV_GAIN_Q32) + (64'sd1 <<< 31), 32);
    zp = asr64(zp * longint'(INV_GAIN_Q32) + (64'sd1 <<< 31), 32);
    turn_vec(xp, zp, tilt);
    r.foot_x = 16'(clip16(asr64(xp + 256, 9)));
    r.foot_z = 16'(clip16(asr64(zp + 256, 9)));
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, result_count);
    fail_count++;
  endtask

  assign pending_count = setpoint_q.size();

  always @(posedge clk) begin
    sfs_out_t want;
    if (!rst_n) begin
      regs <= '{16'sd0, 16'sd0, 16'sd0, 16'd17695, 16'd13107, 15'd5898, 15'd164, 12'd71};
      fail_count = 0;
      result_count <= 0;
      setpoint_q.delete();
    end else begin
      if (in_valid && in_ready) setpoint_q.push_back(foot_setpoint(in_data));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (setpoint_q.size() == 0) begin
          $display("result with nothing expected");
          fail_count++;
        end else begin
          want = setpoint_q.pop_front();
          if (out_data.foot_x !== want.foot_x)
            report_mismatch("foot_x", out_data.foot_x, want.foot_x);
          if (out_data.foot_z !== want.foot_z)
            report_mismatch("foot_z", out_data.foot_z, want.foot_z);
        end
      end
      if (cfg_wr_en) begin
        case (sfs_cfg_idx_t'(cfg_index))
          CFG_FWD_VEL:    regs.forward_velocity <= cfg_wr_data;
          CFG_VERT_VEL:   regs.vertical_velocity <= cfg_wr_data;
          CFG_PITCH_RATE: regs.pitch_rate <= cfg_wr_data;
          CFG_HIP_RADIUS: regs.hip_radius <= cfg_wr_data;
          CFG_INV_GAIN:   regs.inverse_amplitude_gain <= cfg_wr_data;
          CFG_LEG_LENGTH: regs.leg_length <= cfg_wr_data[14:0];
          CFG_VERT_AMP:   regs.vertical_amplitude <= cfg_wr_data[14:0];
          CFG_POINTS:     regs.points_per_stroke <= cfg_wr_data[11:0];
          default: ;
        endcase
      end
    end
  end
endmodule

`default_nettype wire

[tb/sv/swim_stroke_foot_setpoint_tb.sv]
// Testbench top for the swim stroke foot setpoint block: stimulus, settings and verdict.
`timescale 1ns / 1ps
`default_nettype none

module swim_stroke_foot_setpoint_tb;
  import sfs_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  sfs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  sfs_out_t out_data;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_wr_data = '0;
  int fail_count, pending_count, result_count;
  int send_idle_pct = 9, recv_idle_pct = 52;
  int hold_off = 0;
  longint cycle_count = 0;

  always #2 clk = ~clk;

  swim_stroke_foot_setpoint DUT (.*);
  sfs_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Leave valid high on return so items can follow back to back; drain drops it.
  task automatic send_item(logic [1:0] leg, logic [11:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{leg, idx};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(sfs_cfg_idx_t idx, logic [15:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    @(negedge clk);
  endtask

  task automatic random_regs(bit extreme);
    for (int i = 0; i < 8; i++) begin
      logic [15:0] val;
      val = extreme ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      // keep amplitude and leg length mostly modest so outputs stay in range often
      if (!extreme && i >= 5 && $urandom_range(1)) val = 16'($urandom_range(8000));
      if (i == 7 && !extreme && $urandom_range(3) != 0) val = 16'($urandom_range(1, 300));
      write_reg(sfs_cfg_idx_t'(i), val);
    end
  endtask

  task automatic random_items(int count);
    int n;
    for (int i = 0; i < count; i++) begin
      n = $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(400);
      send_item(2'($urandom), 12'(n));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: reset settings, every leg, index edges, zero-vector tilt.
    for (int l = 0; l < 4; l++) send_item(2'(l), 12'(l * 20));
    send_item(2'd0, 12'd0);
    send_item(2'd3, 12'd4095);
    send_item(2'd1, 12'd70);
    send_item(2'd2, 12'd71);
    drain();
    write_reg(CFG_FWD_VEL, 16'h8000);
    write_reg(CFG_VERT_VEL, 16'h7FFF);
    write_reg(CFG_PITCH_RATE, 16'h7FFF);
    write_reg(CFG_HIP_RADIUS, 16'hFFFF);
    write_reg(CFG_INV_GAIN, 16'hFFFF);
    write_reg(CFG_LEG_LENGTH, 16'h7FFF);
    write_reg(CFG_VERT_AMP, 16'h7FFF);
    write_reg(CFG_POINTS, 16'd0);
    for (int l = 0; l < 4; l++) send_item(2'(l), 12'hFFF);
    drain();
    write_reg(CFG_FWD_VEL, 16'h0000);
    write_reg(CFG_VERT_VEL, 16'h0000);
    write_reg(CFG_PITCH_RATE, 16'h8000);
    write_reg(CFG_POINTS, 16'hFFF);
    for (int l = 0; l < 4; l++) send_item(2'(l), 12'(l * 1000 + 7));
    drain();
    write_reg(CFG_PITCH_RATE, 16'h0000);
    send_item(2'd0, 12'd5);
    drain();
    // Long receiver hold-off while items keep coming.
    hold_off <= 200;
    random_items(60);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 9 : ph == 1 ? 52 : 0;
      recv_idle_pct = ph == 0 ? 52 : ph == 1 ? 9 : 0;
      for (int s = 0; s < 6; s++) begin
        random_regs(s == 0);
        random_items(100);
        drain();
      end
    end
    $display("Covered %0d setpoints over extreme and random register settings,", result_count);
    $display("all four legs, index wrap and sender/receiver stall patterns.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire
